>>> rtl/core/aou_pkg.sv
// Shared types, codes and constants of the fixed-point Adam update block.
`default_nettype none

package aou_pkg;

  // Field widths of the input word.
  localparam int unsigned IndexW = 10;
  localparam int unsigned DataW  = 32;

  // Reset values of the configuration registers and of the beta powers.
  localparam logic [23:0] LR_RESET    = 24'd16777;
  localparam logic [15:0] BETA1_RESET = 16'd58982;
  localparam logic [15:0] BETA2_RESET = 16'd65470;
  localparam logic [15:0] EPS_RESET   = 16'd1;
  localparam logic [31:0] POW_ONE     = 32'h8000_0000;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_LEARNING_RATE = 2'd0,
    CFG_BETA_FIRST    = 2'd1,
    CFG_BETA_SECOND   = 2'd2,
    CFG_EPSILON       = 2'd3
  } cfg_idx_e;

  // Operation of the shared divide / square-root unit.
  typedef enum logic {
    DU_DIV  = 1'b0,
    DU_SQRT = 1'b1
  } du_op_e;

  typedef struct packed {
    logic [IndexW-1:0]       element_index;
    logic signed [DataW-1:0] param_value;
    logic signed [DataW-1:0] grad_value;
    logic                    start_of_step;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] new_param;
    logic                    saturated;
  } out_item_t;

  typedef struct packed {
    logic [23:0] learning_rate;
    logic [15:0] beta_first;
    logic [15:0] beta_second;
    logic [15:0] epsilon;
  } cfg_t;

  typedef struct packed {
    logic        start;
    du_op_e      op;
    logic [63:0] num;
    logic [31:0] den;
  } du_req_t;

  typedef struct packed {
    logic        done;
    logic        ovf;
    logic [31:0] quot;
  } du_rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/aou_queue.sv
// Two-entry word queue between the front end and the back end.
`default_nettype none

module aou_queue #(
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  input  wire logic             pop_i,
  output logic                  full_o,
  output logic                  empty_o,
  output logic [Width-1:0]      data_o
);

  logic [Width-1:0] mem_q [2];
  logic             wp_q, wp_d;
  logic             rp_q, rp_d;
  logic [1:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rp_q];

  // Pointer and fill count update.
  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i && !full_o) begin
      wp_d = ~wp_q;
    end
    if (pop_i && !empty_o) begin
      rp_d = ~rp_q;
    end
    if ((push_i && !full_o) && !(pop_i && !empty_o)) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!(push_i && !full_o) && (pop_i && !empty_o)) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage, no reset needed.
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wp_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/aou_front.sv
// Front end: accepts words, advances the beta powers and reduces the index.
`default_nettype none

module aou_front import aou_pkg::*; #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire cfg_t                       cfg_i,
  input  wire logic                       start_i,
  input  wire in_item_t                   item_i,
  input  wire logic                       full_i,
  input  wire logic                       clearing_i,
  output logic                            busy_o,
  output logic                            push_o,
  output logic [AddrW+4*DataW-1:0]        entry_o
);

  localparam int unsigned IdxMax = (1 << IndexW) - 1;
  localparam int unsigned QMax   = IdxMax / Depth;
  localparam int unsigned QBits  = (QMax == 0) ? 0 : $clog2(QMax + 1);

  logic [31:0] pow1_q, pow1_d;
  logic [31:0] pow2_q, pow2_d;
  logic [47:0] prod1, prod2;
  logic [31:0] bc1, bc2;
  logic [AddrW-1:0] idx_mod;

  assign busy_o = full_i | clearing_i;
  assign push_o = start_i & ~busy_o;

  // Index wraps into the store depth by restoring subtraction.
  always_comb begin
    logic [31:0] rem_idx;
    rem_idx = 32'(item_i.element_index);
    for (int b = int'(QBits) - 1; b >= 0; b--) begin
      if (rem_idx >= (32'(Depth) << b)) begin
        rem_idx = rem_idx - (32'(Depth) << b);
      end
    end
    idx_mod = AddrW'(rem_idx);
  end

  // Beta powers advance on the first word of a step.
  assign prod1 = pow1_q * cfg_i.beta_first;
  assign prod2 = pow2_q * cfg_i.beta_second;

  always_comb begin
    pow1_d = pow1_q;
    pow2_d = pow2_q;
    if (push_o && item_i.start_of_step) begin
      pow1_d = prod1[47:16];
      pow2_d = prod2[47:16];
    end
  end

  // Bias correction terms travel with the word.
  assign bc1 = POW_ONE - pow1_d;
  assign bc2 = POW_ONE - pow2_d;

  assign entry_o = {idx_mod, item_i.param_value, item_i.grad_value, bc1, bc2};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pow1_q <= POW_ONE;
      pow2_q <= POW_ONE;
    end else begin
      pow1_q <= pow1_d;
      pow2_q <= pow2_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/aou_divsqrt.sv
// Shared iterative unit: 64/32 division with overflow flag, or 64-bit square root.
`default_nettype none

module aou_divsqrt import aou_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire du_req_t req_i,
  output du_rsp_t      rsp_o
);

  localparam logic [5:0] Steps = 6'd32;

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  du_op_e      op_q, op_d;
  logic        ovf_q, ovf_d;
  logic [63:0] sh_q, sh_d;
  logic [33:0] rem_q, rem_d;
  logic [31:0] q_q, q_d;
  logic [31:0] den_q, den_d;

  logic [33:0] rs_div, rs_sq, trial;

  assign rs_div = {rem_q[32:0], sh_q[63]};
  assign rs_sq  = {rem_q[31:0], sh_q[63:62]};
  assign trial  = {q_q, 2'b01};

  // One quotient or root bit per cycle.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    op_d   = op_q;
    ovf_d  = ovf_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    q_d    = q_q;
    den_d  = den_q;
    if (!busy_q) begin
      if (req_i.start) begin
        busy_d = 1'b1;
        cnt_d  = Steps;
        op_d   = req_i.op;
        den_d  = req_i.den;
        q_d    = '0;
        if (req_i.op == DU_DIV) begin
          rem_d = {2'b00, req_i.num[63:32]};
          sh_d  = {req_i.num[31:0], 32'd0};
          ovf_d = (req_i.num[63:32] >= req_i.den);
        end else begin
          rem_d = '0;
          sh_d  = req_i.num;
          ovf_d = 1'b0;
        end
      end
    end else begin
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
      if (op_q == DU_DIV) begin
        sh_d = {sh_q[62:0], 1'b0};
        if (rs_div >= {2'b00, den_q}) begin
          rem_d = rs_div - {2'b00, den_q};
          q_d   = {q_q[30:0], 1'b1};
        end else begin
          rem_d = rs_div;
          q_d   = {q_q[30:0], 1'b0};
        end
      end else begin
        sh_d = {sh_q[61:0], 2'b00};
        if (rs_sq >= trial) begin
          rem_d = rs_sq - trial;
          q_d   = {q_q[30:0], 1'b1};
        end else begin
          rem_d = rs_sq;
          q_d   = {q_q[30:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= DU_DIV;
      ovf_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
      ovf_q  <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
    q_q   <= q_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.ovf  = ovf_q;
  assign rsp_o.quot = ovf_q ? '1 : q_q;

endmodule

`default_nettype wire

>>> rtl/core/aou_back.sv
// Back end: moment stores, bias correction, update and result register.
`default_nettype none

module aou_back import aou_pkg::*; #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire cfg_t                       cfg_i,
  input  wire logic                       empty_i,
  input  wire logic [AddrW+4*DataW-1:0]   entry_i,
  output logic                            pop_o,
  output logic                            clearing_o,
  output du_req_t                         du_req_o,
  input  wire du_rsp_t                    du_rsp_i,
  output out_item_t                       result_o,
  output logic                            result_valid_o
);

  localparam int unsigned EntryW = AddrW + 4 * DataW;

  localparam logic [4:0] ST_CLR  = 5'd0;
  localparam logic [4:0] ST_IDLE = 5'd1;
  localparam logic [4:0] ST_M1   = 5'd2;
  localparam logic [4:0] ST_M2   = 5'd3;
  localparam logic [4:0] ST_G    = 5'd4;
  localparam logic [4:0] ST_V1   = 5'd5;
  localparam logic [4:0] ST_V2   = 5'd6;
  localparam logic [4:0] ST_MH   = 5'd7;
  localparam logic [4:0] ST_MHW  = 5'd8;
  localparam logic [4:0] ST_VH   = 5'd9;
  localparam logic [4:0] ST_VHW  = 5'd10;
  localparam logic [4:0] ST_SQ   = 5'd11;
  localparam logic [4:0] ST_SQW  = 5'd12;
  localparam logic [4:0] ST_UP   = 5'd13;
  localparam logic [4:0] ST_UPW  = 5'd14;
  localparam logic [4:0] ST_DL   = 5'd15;
  localparam logic [4:0] ST_OUT  = 5'd16;

  // Saturating conversion of a quotient magnitude to a signed word.
  function automatic logic [32:0] sat_quot(logic neg, logic ovf, logic [31:0] q);
    if (neg) begin
      if (ovf || (q > 32'h8000_0000)) begin
        return {1'b1, 32'h8000_0000};
      end
      return {1'b0, 32'(-q)};
    end
    if (ovf || q[31]) begin
      return {1'b1, 32'h7FFF_FFFF};
    end
    return {1'b0, q};
  endfunction

  logic [4:0]              state_q, state_d;
  logic [AddrW-1:0]        clr_q, clr_d;
  logic [AddrW-1:0]        idx_q, idx_d;
  logic signed [31:0]      param_q, param_d;
  logic signed [31:0]      grad_q, grad_d;
  logic [31:0]             bc1_q, bc1_d;
  logic [31:0]             bc2_q, bc2_d;
  logic signed [48:0]      macc_q, macc_d;
  logic signed [31:0]      m_q, m_d;
  logic [39:0]             gsq_q, gsq_d;
  logic [47:0]             vacc_q, vacc_d;
  logic [31:0]             v_q, v_d;
  logic signed [31:0]      mhat_q, mhat_d;
  logic [31:0]             vhat_q, vhat_d;
  logic [31:0]             root_q, root_d;
  logic signed [31:0]      upd_q, upd_d;
  logic signed [32:0]      delta_q, delta_d;
  logic                    flag_q, flag_d;
  out_item_t               res_q, res_d;
  logic                    rv_q, rv_d;

  // Moment stores and their ports.
  logic signed [31:0] m_mem [Depth];
  logic [31:0]        v_mem [Depth];
  logic signed [31:0] m_rd_q;
  logic [31:0]        v_rd_q;
  logic               mem_re;
  logic [AddrW-1:0]   rd_addr;
  logic               m_we, v_we;
  logic [AddrW-1:0]   wr_addr;
  logic signed [31:0] m_wdata;
  logic [31:0]        v_wdata;

  // Datapath terms.
  logic [31:0]        gabs, mmag, mhmag;
  logic [16:0]        b1c, b2c;
  logic signed [48:0] macc_mul;
  logic signed [49:0] mg_mul;
  logic signed [50:0] msum;
  logic [63:0]        gsq_full;
  logic [47:0]        vmul;
  logic [56:0]        vg_mul;
  logic [57:0]        vsum;
  logic               v_sat;
  logic [32:0]        den_sum;
  logic [31:0]        den_w;
  logic signed [56:0] dprod;
  logic signed [33:0] res_wide;
  logic               res_sat;
  logic [32:0]        sq_res;

  assign rd_addr = entry_i[EntryW-1 -: AddrW];

  assign gabs  = grad_q[31] ? 32'(-grad_q) : 32'(grad_q);
  assign mmag  = m_q[31] ? 32'(-m_q) : 32'(m_q);
  assign mhmag = mhat_q[31] ? 32'(-mhat_q) : 32'(mhat_q);
  assign b1c   = 17'h1_0000 - {1'b0, cfg_i.beta_first};
  assign b2c   = 17'h1_0000 - {1'b0, cfg_i.beta_second};

  // First moment: two multiply steps with a floor shift.
  assign macc_mul = $signed({1'b0, cfg_i.beta_first}) * m_rd_q;
  assign mg_mul   = $signed({1'b0, b1c}) * grad_q;
  assign msum     = 51'(macc_q) + 51'(mg_mul);

  // Second moment: squared gradient then decay with saturation.
  assign gsq_full = gabs * gabs;
  assign vmul     = cfg_i.beta_second * v_rd_q;
  assign vg_mul   = b2c * gsq_q;
  assign vsum     = 58'(vacc_q) + 58'(vg_mul);
  assign v_sat    = |vsum[57:48];

  // Denominator of the update, never zero.
  assign den_sum = 33'(root_q) + 33'(cfg_i.epsilon);
  assign den_w   = (den_sum == 33'd0) ? 32'd1 : den_sum[31:0];

  // Scaled step and final subtraction.
  assign dprod    = $signed({1'b0, cfg_i.learning_rate}) * upd_q;
  assign res_wide = 34'(param_q) - 34'(delta_q);
  assign res_sat  = (res_wide[33:31] != 3'b000) && (res_wide[33:31] != 3'b111);

  assign sq_res = sat_quot(state_q == ST_MHW ? m_q[31] : mhat_q[31],
                           du_rsp_i.ovf, du_rsp_i.quot);

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    idx_d    = idx_q;
    param_d  = param_q;
    grad_d   = grad_q;
    bc1_d    = bc1_q;
    bc2_d    = bc2_q;
    macc_d   = macc_q;
    m_d      = m_q;
    gsq_d    = gsq_q;
    vacc_d   = vacc_q;
    v_d      = v_q;
    mhat_d   = mhat_q;
    vhat_d   = vhat_q;
    root_d   = root_q;
    upd_d    = upd_q;
    delta_d  = delta_q;
    flag_d   = flag_q;
    res_d    = res_q;
    rv_d     = 1'b0;
    pop_o    = 1'b0;
    mem_re   = 1'b0;
    m_we     = 1'b0;
    v_we     = 1'b0;
    wr_addr  = idx_q;
    m_wdata  = m_d;
    v_wdata  = v_d;
    du_req_o = '{start: 1'b0, op: DU_DIV, num: 64'd0, den: 32'd1};
    unique case (state_q)
      ST_CLR: begin
        m_we    = 1'b1;
        v_we    = 1'b1;
        wr_addr = clr_q;
        m_wdata = '0;
        v_wdata = '0;
        if (clr_q == AddrW'(Depth - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + AddrW'(1);
        end
      end
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          mem_re  = 1'b1;
          idx_d   = rd_addr;
          param_d = $signed(entry_i[4*DataW-1 -: DataW]);
          grad_d  = $signed(entry_i[3*DataW-1 -: DataW]);
          bc1_d   = entry_i[2*DataW-1 -: DataW];
          bc2_d   = entry_i[DataW-1:0];
          flag_d  = 1'b0;
          state_d = ST_M1;
        end
      end
      ST_M1: begin
        macc_d  = macc_mul;
        state_d = ST_M2;
      end
      ST_M2: begin
        m_d     = msum[47:16];
        m_we    = 1'b1;
        m_wdata = msum[47:16];
        state_d = ST_G;
      end
      ST_G: begin
        gsq_d   = gsq_full[63:24];
        state_d = ST_V1;
      end
      ST_V1: begin
        vacc_d  = vmul;
        state_d = ST_V2;
      end
      ST_V2: begin
        v_d     = v_sat ? '1 : vsum[47:16];
        v_we    = 1'b1;
        v_wdata = v_sat ? '1 : vsum[47:16];
        flag_d  = flag_q | v_sat;
        state_d = ST_MH;
      end
      ST_MH: begin
        if (bc1_q == 32'd0) begin
          mhat_d  = m_q;
          state_d = ST_VH;
        end else begin
          du_req_o = '{start: 1'b1, op: DU_DIV, num: {1'b0, mmag, 31'd0}, den: bc1_q};
          state_d  = ST_MHW;
        end
      end
      ST_MHW: begin
        if (du_rsp_i.done) begin
          mhat_d  = $signed(sq_res[31:0]);
          flag_d  = flag_q | sq_res[32];
          state_d = ST_VH;
        end
      end
      ST_VH: begin
        if (bc2_q == 32'd0) begin
          vhat_d  = v_q;
          state_d = ST_SQ;
        end else begin
          du_req_o = '{start: 1'b1, op: DU_DIV, num: {1'b0, v_q, 31'd0}, den: bc2_q};
          state_d  = ST_VHW;
        end
      end
      ST_VHW: begin
        if (du_rsp_i.done) begin
          vhat_d  = du_rsp_i.quot;
          flag_d  = flag_q | du_rsp_i.ovf;
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        du_req_o = '{start: 1'b1, op: DU_SQRT, num: {8'd0, vhat_q, 24'd0}, den: 32'd1};
        state_d  = ST_SQW;
      end
      ST_SQW: begin
        if (du_rsp_i.done) begin
          root_d  = du_rsp_i.quot;
          state_d = ST_UP;
        end
      end
      ST_UP: begin
        du_req_o = '{start: 1'b1, op: DU_DIV, num: {8'd0, mhmag, 24'd0}, den: den_w};
        state_d  = ST_UPW;
      end
      ST_UPW: begin
        if (du_rsp_i.done) begin
          upd_d   = $signed(sq_res[31:0]);
          flag_d  = flag_q | sq_res[32];
          state_d = ST_DL;
        end
      end
      ST_DL: begin
        delta_d = dprod[56:24];
        state_d = ST_OUT;
      end
      ST_OUT: begin
        res_d.new_param = res_sat ? (res_wide[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                                  : res_wide[31:0];
        res_d.saturated = flag_q | res_sat;
        rv_d            = 1'b1;
        state_d         = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      clr_q   <= '0;
      rv_q    <= 1'b0;
      flag_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      rv_q    <= rv_d;
      flag_q  <= flag_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    param_q <= param_d;
    grad_q  <= grad_d;
    bc1_q   <= bc1_d;
    bc2_q   <= bc2_d;
    macc_q  <= macc_d;
    m_q     <= m_d;
    gsq_q   <= gsq_d;
    vacc_q  <= vacc_d;
    v_q     <= v_d;
    mhat_q  <= mhat_d;
    vhat_q  <= vhat_d;
    root_q  <= root_d;
    upd_q   <= upd_d;
    delta_q <= delta_d;
    res_q   <= res_d;
  end

  // First moment store.
  always_ff @(posedge clk_i) begin
    if (m_we) begin
      m_mem[wr_addr] <= m_wdata;
    end
    if (mem_re) begin
      m_rd_q <= m_mem[rd_addr];
    end
  end

  // Second moment store.
  always_ff @(posedge clk_i) begin
    if (v_we) begin
      v_mem[wr_addr] <= v_wdata;
    end
    if (mem_re) begin
      v_rd_q <= v_mem[rd_addr];
    end
  end

  assign clearing_o     = (state_q == ST_CLR);
  assign result_o       = res_q;
  assign result_valid_o = rv_q;

endmodule

`default_nettype wire

>>> rtl/core/adam_optimizer_update.sv
// Top level of the fixed-point Adam parameter update block.
//
// A word (element index, parameter, gradient, start-of-step flag) is taken
// at a rising edge where start is high and busy is low. Configuration is
// written through cfg_we_i / cfg_idx_i / cfg_wdata_i at any edge, no wait.
// Each word yields one result on result_o, marked by result_valid_o for
// exactly one cycle; the receiver cannot stall it.
// The front end advances the beta powers and reduces the index, then
// parks the word in a two-entry queue, so up to two words are taken while
// the back end is still working. The back end updates both moments and
// runs three divisions and one square root on a shared unit that retires
// one quotient or root bit per cycle.
// The back end works on one word at a time, and each bias correction is
// skipped for words that come before the first step. Under load its pace
// is set by the four operations on the shared unit.
// After reset the back end sweeps both moment stores to zero, one entry a
// cycle, and holds busy high meanwhile.
`default_nettype none

module adam_optimizer_update import aou_pkg::*; #(
  parameter int unsigned Depth = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    in_i,
  output out_item_t        result_o,
  output logic             result_valid_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [23:0] cfg_wdata_i
);

  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned EntryW = AddrW + 4 * DataW;

  cfg_t              cfg_q;
  logic              push, pop, q_full, q_empty, clearing;
  logic [EntryW-1:0] push_entry, head_entry;
  du_req_t           du_req;
  du_rsp_t           du_rsp;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.learning_rate <= LR_RESET;
      cfg_q.beta_first    <= BETA1_RESET;
      cfg_q.beta_second   <= BETA2_RESET;
      cfg_q.epsilon       <= EPS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LEARNING_RATE: cfg_q.learning_rate <= cfg_wdata_i;
        CFG_BETA_FIRST:    cfg_q.beta_first    <= cfg_wdata_i[15:0];
        CFG_BETA_SECOND:   cfg_q.beta_second   <= cfg_wdata_i[15:0];
        CFG_EPSILON:       cfg_q.epsilon       <= cfg_wdata_i[15:0];
        default: begin
        end
      endcase
    end
  end

  aou_front #(.Depth(Depth), .AddrW(AddrW)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .start_i    (start),
    .item_i     (in_i),
    .full_i     (q_full),
    .clearing_i (clearing),
    .busy_o     (busy),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  aou_queue #(.Width(EntryW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .data_o  (head_entry)
  );

  aou_divsqrt u_divsqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (du_req),
    .rsp_o  (du_rsp)
  );

  aou_back #(.Depth(Depth), .AddrW(AddrW)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .empty_i        (q_empty),
    .entry_i        (head_entry),
    .pop_o          (pop),
    .clearing_o     (clearing),
    .du_req_o       (du_req),
    .du_rsp_i       (du_rsp),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

  // Results are spaced by the sequencer, never in adjacent cycles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for two cycles");

  // No word is taken while the stores are being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> busy)
    else $error("busy low during store clearing");

  // No result can appear during the clearing sweep.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !result_valid_o)
    else $error("result during store clearing");

endmodule

`default_nettype wire

>>> bench/tb_adam_optimizer_update.sv
// Self-checking testbench for the fixed-point Adam parameter update block.
`timescale 1ns / 100ps

module tb_adam_optimizer_update;
  import aou_pkg::*;

  localparam int unsigned MomentDepth = 1024;

  // Predicts each updated parameter and holds the expected words in order.
  class adam_scoreboard;
    int               errors;
    out_item_t        expected_q[$];
    logic signed [31:0] first_mom[MomentDepth];
    logic [31:0]      second_mom[MomentDepth];
    logic [31:0]      pow1;
    logic [31:0]      pow2;
    logic [23:0]      lr;
    logic [15:0]      b1;
    logic [15:0]      b2;
    logic [15:0]      eps;

    function new();
      errors = 0;
      for (int i = 0; i < MomentDepth; i++) begin
        first_mom[i] = '0;
        second_mom[i] = '0;
      end
      pow1 = POW_ONE;
      pow2 = POW_ONE;
      lr = LR_RESET;
      b1 = BETA1_RESET;
      b2 = BETA2_RESET;
      eps = EPS_RESET;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [23:0] data);
      case (idx)
        CFG_LEARNING_RATE: lr = data;
        CFG_BETA_FIRST:    b1 = data[15:0];
        CFG_BETA_SECOND:   b2 = data[15:0];
        CFG_EPSILON:       eps = data[15:0];
        default: ;
      endcase
    endfunction

    // Integer square root, one result bit per iteration.
    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root;
      longint unsigned probe;
      root = 0;
      probe = 64'd1 << 62;
      while (probe > n) probe = probe >> 2;
      while (probe != 0) begin
        if (n >= root + probe) begin
          n = n - (root + probe);
          root = (root >> 1) + probe;
        end else begin
          root = root >> 1;
        end
        probe = probe >> 2;
      end
      return root;
    endfunction

    // Signed quotient truncated toward zero, clipped to 32 bits.
    function longint clip_quot(bit neg, longint unsigned mag, longint unsigned den,
                               ref bit clipped);
      longint unsigned q;
      q = mag / den;
      if (neg) begin
        if (q > 64'd2147483648) begin
          clipped = 1'b1;
          q = 64'd2147483648;
        end
        return -longint'(q);
      end
      if (q > 64'd2147483647) begin
        clipped = 1'b1;
        q = 64'd2147483647;
      end
      return longint'(q);
    endfunction

    // Works out the result of one accepted word and queues it.
    function void note_word(in_item_t w);
      bit clipped;
      int unsigned idx;
      longint g, m, m_hat, upd, delta, res;
      longint unsigned mag, gsq, vacc, v_hat, bc1, bc2, den;
      out_item_t exp_w;
      clipped = 1'b0;
      idx = w.element_index % MomentDepth;
      g = longint'(w.grad_value);
      if (w.start_of_step) begin
        pow1 = 32'((64'(pow1) * 64'(b1)) >> 16);
        pow2 = 32'((64'(pow2) * 64'(b2)) >> 16);
      end
      m = (longint'(b1) * longint'(first_mom[idx]) + (65536 - longint'(b1)) * g) >>> 16;
      first_mom[idx] = 32'(m);
      mag = (g < 0) ? longint'(-g) : longint'(g);
      gsq = (mag * mag) >> 24;
      vacc = (64'(b2) * 64'(second_mom[idx]) + (64'd65536 - 64'(b2)) * gsq) >> 16;
      if (vacc > 64'hFFFF_FFFF) begin
        clipped = 1'b1;
        vacc = 64'hFFFF_FFFF;
      end
      second_mom[idx] = 32'(vacc);
      bc1 = 64'h8000_0000 - 64'(pow1);
      bc2 = 64'h8000_0000 - 64'(pow2);
      // With no step started the bias correction is skipped.
      if (bc1 == 0) begin
        m_hat = m;
      end else begin
        mag = (m < 0) ? longint'(-m) : longint'(m);
        m_hat = clip_quot(m < 0, mag << 31, bc1, clipped);
      end
      if (bc2 == 0) begin
        v_hat = vacc;
      end else begin
        v_hat = (vacc << 31) / bc2;
        if (v_hat > 64'hFFFF_FFFF) begin
          clipped = 1'b1;
          v_hat = 64'hFFFF_FFFF;
        end
      end
      den = int_sqrt(v_hat << 24) + 64'(eps);
      if (den == 0) den = 1;
      mag = (m_hat < 0) ? longint'(-m_hat) : longint'(m_hat);
      upd = clip_quot(m_hat < 0, mag << 24, den, clipped);
      delta = (longint'(lr) * upd) >>> 24;
      res = longint'(w.param_value) - delta;
      if (res > 64'sd2147483647) begin
        clipped = 1'b1;
        res = 64'sd2147483647;
      end else if (res < -64'sd2147483648) begin
        clipped = 1'b1;
        res = -64'sd2147483648;
      end
      exp_w.new_param = 32'(res);
      exp_w.saturated = clipped;
      expected_q.insert(expected_q.size(), exp_w);
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_word(out_item_t got);
      out_item_t exp_w;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected word new_param=%h", got.new_param));
        return;
      end
      exp_w = expected_q.pop_front();
      if (got.new_param !== exp_w.new_param)
        report($sformatf("new_param got %h expected %h", got.new_param, exp_w.new_param));
      if (got.saturated !== exp_w.saturated)
        report($sformatf("saturated got %b expected %b", got.saturated, exp_w.saturated));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  in_item_t    in_i;
  out_item_t   result_o;
  logic        result_valid_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [23:0] cfg_wdata_i;

  adam_scoreboard sb;
  bit             no_idle;

  adam_optimizer_update dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_i           (in_i),
    .result_o       (result_o),
    .result_valid_o (result_valid_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #30_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Every result word is checked at the edge that ends its cycle.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) sb.check_word(result_o);
  end

  // Sends one word, waits for it to be taken, then sometimes idles for a random burst.
  task send_word(in_item_t w);
    int gap;
    start <= 1'b1;
    in_i <= w;
    do @(posedge clk_i); while (busy);
    sb.note_word(w);
    gap = (!no_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Holds the write enable high; the caller drops it after its last write.
  task write_reg(cfg_idx_e idx, logic [23:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  // Lets every pending word drain and the back end settle.
  task drain();
    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task write_all(logic [23:0] lr, logic [15:0] b1, logic [15:0] b2, logic [15:0] eps);
    write_reg(CFG_LEARNING_RATE, lr);
    write_reg(CFG_BETA_FIRST, {8'd0, b1});
    write_reg(CFG_BETA_SECOND, {8'd0, b2});
    write_reg(CFG_EPSILON, {8'd0, eps});
    cfg_we_i <= 1'b0;
  endtask

  function in_item_t make_word(logic [9:0] idx, logic [31:0] p, logic [31:0] g, bit sos);
    in_item_t w;
    w.element_index = idx;
    w.param_value = p;
    w.grad_value = g;
    w.start_of_step = sos;
    return w;
  endfunction

  // Random optimizer steps: a first element that is usually flagged, then a few more.
  task random_steps(int count);
    int sent, len;
    logic [9:0] pool_base;
    logic [31:0] g;
    sent = 0;
    while (sent < count) begin
      len = $urandom_range(1, 8);
      pool_base = 10'($urandom_range(0, 1023));
      for (int k = 0; k < len && sent < count; k++) begin
        case ($urandom_range(0, 3))
          0: g = $urandom;
          1: g = 32'($signed($urandom_range(0, 2_000_000)) - 1_000_000);
          2: g = 32'($signed($urandom_range(0, 60_000_000)) - 30_000_000);
          default: g = {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
        endcase
        // Revisit a small pool so moments build up over steps.
        send_word(make_word(($urandom_range(0, 4) == 0) ? 10'($urandom_range(0, 1023))
                                                        : pool_base + 10'(k % 3),
                            $urandom, g,
                            (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0)));
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    no_idle = 1'b0;
    rst_ni = 1'b0;
    start = 1'b0;
    in_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_LEARNING_RATE;
    cfg_wdata_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words; the first ones come before any step, so no bias correction.
    send_word(make_word(10'd0, 32'h0100_0000, 32'h0100_0000, 1'b0));
    send_word(make_word(10'd1023, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
    send_word(make_word(10'd5, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
    send_word(make_word(10'd0, 32'h0, 32'h0, 1'b1));
    send_word(make_word(10'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    send_word(make_word(10'd1023, 32'h8000_0000, 32'h8000_0000, 1'b1));
    send_word(make_word(10'd512, 32'h0, 32'h0000_0001, 1'b0));
    drain();
    // Largest step size, extreme betas, zero guard: the zero denominator case.
    write_all(24'hFF_FFFF, 16'd1, 16'd65535, 16'd0);
    send_word(make_word(10'd300, 32'h0, 32'h0, 1'b1));
    send_word(make_word(10'd301, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
    send_word(make_word(10'd302, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
    send_word(make_word(10'd300, 32'h1234_5678, 32'h0000_0100, 1'b0));
    drain();
    // Zero step size and zero betas, largest guard.
    write_all(24'd0, 16'd0, 16'd0, 16'hFFFF);
    send_word(make_word(10'd7, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));
    send_word(make_word(10'd8, 32'h8000_0000, 32'h8000_0000, 1'b1));
    send_word(make_word(10'd9, 32'h0000_0000, 32'hFF00_0000, 1'b0));
    drain();

    // Random phases over several register settings.
    write_all(LR_RESET, BETA1_RESET, BETA2_RESET, EPS_RESET);
    random_steps(360);
    drain();
    write_all(24'hFF_FFFF, 16'd65535, 16'd65535, 16'd65535);
    random_steps(360);
    drain();
    write_all(24'd1, 16'd1, 16'd1, 16'd1);
    random_steps(360);
    drain();
    write_all(24'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    random_steps(360);
    drain();
    write_all(24'($urandom_range(1, 4_000_000)), 16'($urandom_range(50_000, 65535)),
              16'($urandom_range(60_000, 65535)), 16'($urandom_range(0, 100)));
    no_idle = 1'b1;
    random_steps(360);
    drain();

    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
